### rtl/core/twri_pkg.sv
package twri_pkg;

  // Field widths
  localparam int unsigned DurW     = 24;
  localparam int unsigned ValW     = 32;
  localparam int unsigned RepW     = 9;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned TimeW    = 26;
  localparam int unsigned FracW    = 16;
  localparam int unsigned SpanW    = ValW + 1;
  localparam int unsigned RemW     = DurW + 1;
  localparam int unsigned AluW     = SpanW + FracW + 1;
  localparam int unsigned CntW     = $clog2(FracW);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDuration   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartDelay = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRepeat     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYoyo       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStartValue = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEndValue   = 3'd5;

  // One second in Q8.16
  localparam logic [DurW-1:0] DurationRst = 24'd65536;

  typedef struct packed {
    logic [DurW-1:0]        duration;
    logic [DurW-1:0]        start_delay;
    logic signed [RepW-1:0] repeat_count;
    logic                   yoyo_enable;
    logic signed [ValW-1:0] start_value;
    logic signed [ValW-1:0] end_value;
  } cfg_t;

  typedef struct packed {
    logic signed [AluW-1:0] op_a;
    logic signed [AluW-1:0] op_b;
    logic                   sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [ValW-1:0] ramp_value;
    logic                   value_valid;
    logic                   done_pulse;
    logic                   is_running;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_RANGE,
    S_DELAY,
    S_DEN,
    S_CMP,
    S_DIV,
    S_SPAN,
    S_MUL,
    S_SUM,
    S_OUT
  } state_e;

endpackage

### rtl/core/twri_alu.sv
module twri_alu import twri_pkg::*; (
  input  alu_req_t               req_i,
  output logic signed [AluW-1:0] sum_o,
  output logic                   neg_o,
  output logic                   zero_o
);

  // Shared adder/subtractor with sign and zero flags
  always_comb begin
    if (req_i.sub) begin
      sum_o = req_i.op_a - req_i.op_b;
    end else begin
      sum_o = req_i.op_a + req_i.op_b;
    end
    neg_o  = sum_o[AluW-1];
    zero_o = (sum_o == '0);
  end

endmodule

### rtl/core/twri_core.sv
module twri_core import twri_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              start_i,
  input  logic [DeltaW-1:0] tick_delta_i,
  input  logic              restart_i,
  output logic              busy_o,
  output res_t              res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);

  state_e                 state_q, state_d;
  logic signed [TimeW-1:0] elapsed_q, elapsed_d;
  logic                   dir_q, dir_d;
  logic signed [RepW-1:0] reps_q, reps_d;
  logic                   running_q, running_d;
  logic                   done_q, done_d;
  logic [DeltaW-1:0]      delta_q, delta_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [DurW-1:0]        den_q, den_d;
  logic [FracW-1:0]       quo_q, quo_d;
  logic [AluW-1:0]        acc_q, acc_d;
  logic [SpanW-1:0]       span_q, span_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  res_t                   res_q, res_d;

  alu_req_t               alu_req;
  logic signed [AluW-1:0] alu_sum;
  logic                   alu_neg;
  logic                   alu_zero;

  twri_alu u_alu (
    .req_i  (alu_req),
    .sum_o  (alu_sum),
    .neg_o  (alu_neg),
    .zero_o (alu_zero)
  );

  // Hold the sequencer and tween state registers; the datapath registers follow below
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      elapsed_q <= '0;
      dir_q     <= 1'b0;
      reps_q    <= '0;
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      dir_q     <= dir_d;
      reps_q    <= reps_d;
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    acc_q   <= acc_d;
    span_q  <= span_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

  // Sequence one tick through the shared adder
  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    dir_d     = dir_q;
    reps_d    = reps_q;
    running_d = running_q;
    done_d    = done_q;
    delta_d   = delta_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quo_d     = quo_q;
    acc_d     = acc_q;
    span_d    = span_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    alu_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          delta_d = tick_delta_i;
          if (restart_i) begin
            elapsed_d = '0;
            dir_d     = 1'b0;
            reps_d    = cfg_i.repeat_count;
            running_d = 1'b1;
            done_d    = 1'b0;
          end
          state_d = S_TICK;
        end
      end

      // Advance or rewind the elapsed time by the tick delta; a stopped tween goes straight to the result
      S_TICK: begin
        if (!running_q) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          alu_req.op_a = AluW'(elapsed_q);
          alu_req.op_b = AluW'(delta_q);
          alu_req.sub  = dir_q;
          elapsed_d    = alu_sum[TimeW-1:0];
          state_d      = S_RANGE;
        end
      end

      // Check the time against the cycle bounds; repeat or finish when it leaves them
      S_RANGE: begin
        alu_req.op_a = AluW'(cfg_i.duration);
        alu_req.op_b = AluW'(elapsed_q);
        alu_req.sub  = 1'b1;
        state_d      = S_DELAY;
        if (alu_neg || elapsed_q[TimeW-1]) begin
          if (reps_q != '0) begin
            if (!reps_q[RepW-1]) begin
              reps_d = reps_q - RepW'(1);
            end
            if (cfg_i.yoyo_enable) begin
              dir_d = ~dir_q;
            end else begin
              elapsed_d = '0;
            end
          end else begin
            elapsed_d             = TimeW'(cfg_i.duration);
            running_d             = 1'b0;
            done_d                = 1'b1;
            res_d                 = '0;
            res_d.done_pulse      = 1'b1;
            state_d               = S_OUT;
          end
        end
      end

      // Numerator: time past the start delay
      S_DELAY: begin
        alu_req.op_a = AluW'(elapsed_q);
        alu_req.op_b = AluW'(cfg_i.start_delay);
        alu_req.sub  = 1'b1;
        if (alu_neg) begin
          res_d            = '0;
          res_d.is_running = running_q;
          state_d          = S_OUT;
        end else begin
          rem_d   = alu_sum[RemW-1:0];
          state_d = S_DEN;
        end
      end

      // Denominator: ramp length; an empty or negative ramp gives the end value
      S_DEN: begin
        alu_req.op_a = AluW'(cfg_i.duration);
        alu_req.op_b = AluW'(cfg_i.start_delay);
        alu_req.sub  = 1'b1;
        if (alu_neg || alu_zero) begin
          res_d.ramp_value  = cfg_i.end_value;
          res_d.value_valid = 1'b1;
          res_d.done_pulse  = 1'b0;
          res_d.is_running  = running_q;
          state_d           = S_OUT;
        end else begin
          den_d   = alu_sum[DurW-1:0];
          state_d = S_CMP;
        end
      end

      // Clamp the fraction to one when the numerator reaches the denominator
      S_CMP: begin
        alu_req.op_a = AluW'(rem_q);
        alu_req.op_b = AluW'(den_q);
        alu_req.sub  = 1'b1;
        if (!alu_neg) begin
          res_d.ramp_value  = cfg_i.end_value;
          res_d.value_valid = 1'b1;
          res_d.done_pulse  = 1'b0;
          res_d.is_running  = running_q;
          state_d           = S_OUT;
        end else begin
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        alu_req.op_a = AluW'({rem_q, 1'b0});
        alu_req.op_b = AluW'(den_q);
        alu_req.sub  = 1'b1;
        if (alu_neg) begin
          rem_d = {rem_q[RemW-2:0], 1'b0};
        end else begin
          rem_d = alu_sum[RemW-1:0];
        end
        quo_d = {quo_q[FracW-2:0], ~alu_neg};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(FracW - 1)) begin
          state_d = S_SPAN;
        end
      end

      // Span of the ramp, one bit wider than a value
      S_SPAN: begin
        alu_req.op_a = AluW'(cfg_i.end_value);
        alu_req.op_b = AluW'(cfg_i.start_value);
        alu_req.sub  = 1'b1;
        span_d       = alu_sum[SpanW-1:0];
        acc_d        = '0;
        cnt_d        = '0;
        state_d      = S_MUL;
      end

      // Shift-and-add multiply, fraction MSB first
      S_MUL: begin
        alu_req.op_a = $signed({acc_q[AluW-2:0], 1'b0});
        alu_req.op_b = quo_q[FracW-1] ? AluW'($signed(span_q)) : '0;
        alu_req.sub  = 1'b0;
        acc_d        = alu_sum;
        quo_d        = {quo_q[FracW-2:0], 1'b0};
        cnt_d        = cnt_q + CntW'(1);
        if (cnt_q == CntW'(FracW - 1)) begin
          state_d = S_SUM;
        end
      end

      // Drop the fraction bits (floor) and add the start value
      S_SUM: begin
        alu_req.op_a      = AluW'(cfg_i.start_value);
        alu_req.op_b      = AluW'($signed(acc_q[AluW-1:FracW]));
        alu_req.sub       = 1'b0;
        res_d.ramp_value  = alu_sum[ValW-1:0];
        res_d.value_valid = 1'b1;
        res_d.done_pulse  = 1'b0;
        res_d.is_running  = running_q;
        state_d           = S_OUT;
      end

      // Hand the result over once the output register is free
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < RemW'(den_q)))
    else $error("division remainder not below denominator");

  a_done_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !running_q)
    else $error("finished tween still running");

  a_pulse_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_q.done_pulse) |-> (!res_q.value_valid && !res_q.is_running))
    else $error("done pulse with value or running flag");

  a_value_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_q.value_valid) |-> res_q.is_running)
    else $error("value produced while not running");

  a_start_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (state_q == S_TICK))
    else $error("accepted tick not processed");
`endif

endmodule

### rtl/core/tween_ramp_interpolator_unit.sv
// Linear tween with repeat and yoyo.
// Input channel (in_valid_i / in_stall_o): one transaction per time tick,
// carrying a Q0.16 tick delta and a restart flag. Output channel
// (out_valid_o / out_stall_i): exactly one transaction per tick, with the
// interpolated value, its valid flag, the done pulse and the running flag.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write it only while no tick is in flight, which the block
// itself does not enforce. Indexes above 5 are ignored. Each tick steps
// through the sequencer: a stopped tween goes straight to the result, the
// finishing tick ends after the bounds check, and a tick below the start
// delay, an empty ramp or a fraction clamped to one each end early; a full
// interpolation runs the 16-step division and 16-step multiply that share
// one 50-bit adder. A new tick is taken only once the previous result has
// left the sequencer for the output register, so ticks never overlap.
// Reset: configuration returns to its defaults (duration one second), the
// tween is stopped and the output register is empty.
// While out_stall_i holds, the output register keeps its transaction and
// the sequencer waits with the next result, so no new tick is taken.
module tween_ramp_interpolator_unit import twri_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [DeltaW-1:0]      tick_delta_i,
  input  logic                   restart_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [ValW-1:0] ramp_value_o,
  output logic                   value_valid_o,
  output logic                   done_pulse_o,
  output logic                   is_running_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic out_valid_q, out_valid_d;
  res_t out_res_q;
  res_t core_res;
  logic core_busy;
  logic core_res_valid;
  logic core_res_ready;
  logic start;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDuration:   cfg_d.duration     = cfg_data_i[DurW-1:0];
        RegStartDelay: cfg_d.start_delay  = cfg_data_i[DurW-1:0];
        RegRepeat:     cfg_d.repeat_count = cfg_data_i[RepW-1:0];
        RegYoyo:       cfg_d.yoyo_enable  = cfg_data_i[0];
        RegStartValue: cfg_d.start_value  = cfg_data_i[ValW-1:0];
        RegEndValue:   cfg_d.end_value    = cfg_data_i[ValW-1:0];
        default:       cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration     <= DurationRst;
      cfg_q.start_delay  <= '0;
      cfg_q.repeat_count <= '0;
      cfg_q.yoyo_enable  <= 1'b0;
      cfg_q.start_value  <= '0;
      cfg_q.end_value    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept a tick only while the sequencer is idle
  assign in_stall_o = core_busy;
  assign start      = in_valid_i && !core_busy;

  twri_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (start),
    .tick_delta_i (tick_delta_i),
    .restart_i    (restart_i),
    .busy_o       (core_busy),
    .res_o        (core_res),
    .res_valid_o  (core_res_valid),
    .res_ready_i  (core_res_ready)
  );

  // Output register: load when empty or being drained, drop when taken
  assign core_res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_res_valid && core_res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_valid && core_res_ready) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ramp_value_o  = out_res_q.ramp_value;
  assign value_valid_o = out_res_q.value_valid;
  assign done_pulse_o  = out_res_q.done_pulse;
  assign is_running_o  = out_res_q.is_running;

endmodule

### dv/tb_tween_ramp_interpolator_unit.sv
module tb_tween_ramp_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import twri_pkg::*;

  localparam int unsigned SettleCycles = 12;
  localparam int unsigned DrainLimit   = 200000;
  localparam int unsigned ShowLimit    = 10;

  // Indexes past the last register, to be ignored by the block
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [DeltaW-1:0]      DeltaMax = {DeltaW{1'b1}};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [DeltaW-1:0]      tick_delta_i;
  logic                   restart_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [ValW-1:0] ramp_value_o;
  logic                   value_valid_o;
  logic                   done_pulse_o;
  logic                   is_running_o;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  tween_ramp_interpolator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tick_delta_i  (tick_delta_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ramp_value_o  (ramp_value_o),
    .value_valid_o (value_valid_o),
    .done_pulse_o  (done_pulse_o),
    .is_running_o  (is_running_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of configuration and tween state
  cfg_t cfg_q;
  int   elapsed_q;
  bit   count_down_q;
  int   repeats_left_q;
  bit   running_q;
  bit   finished_q;

  res_t        pending_ramp_q[$];
  int unsigned fail_cnt;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Value on the ramp at time t
  function automatic logic signed [ValW-1:0] ramp_at(input int t);
    longint num;
    longint den;
    longint frac;
    longint span;
    num = longint'(t) - longint'(cfg_q.start_delay);
    den = longint'(cfg_q.duration) - longint'(cfg_q.start_delay);
    if (num < 0) num = 0;
    if (den <= 0) begin
      frac = 65536;
    end else begin
      frac = (num * 65536) / den;
      if (frac > 65536) frac = 65536;
    end
    span = longint'(cfg_q.end_value) - longint'(cfg_q.start_value);
    return ValW'(longint'(cfg_q.start_value) + ((frac * span) >>> FracW));
  endfunction

  // Advance the tween by one tick and give the transaction it produces
  function automatic res_t predict_tick(input logic [DeltaW-1:0] delta, input logic restart);
    res_t r;
    bit   ended;
    int   dur;
    r     = '0;
    ended = 1'b0;
    dur   = int'(cfg_q.duration);
    if (restart) begin
      elapsed_q      = 0;
      count_down_q   = 1'b0;
      repeats_left_q = int'(cfg_q.repeat_count);
      running_q      = 1'b1;
      finished_q     = 1'b0;
    end
    if (running_q) begin
      elapsed_q += count_down_q ? -int'(delta) : int'(delta);
      if (elapsed_q > dur || elapsed_q < 0) begin
        if (repeats_left_q != 0) begin
          // negative count never runs out
          if (repeats_left_q > 0) repeats_left_q--;
          if (cfg_q.yoyo_enable) count_down_q = !count_down_q;
          else elapsed_q = 0;
        end else begin
          elapsed_q    = dur;
          running_q    = 1'b0;
          finished_q   = 1'b1;
          r.done_pulse = 1'b1;
          ended        = 1'b1;
        end
      end
      if (!ended && elapsed_q >= int'(cfg_q.start_delay)) begin
        r.ramp_value  = ramp_at(elapsed_q);
        r.value_valid = 1'b1;
      end
    end
    r.is_running = running_q;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= ShowLimit) $display("[%0t] %s", $realtime, msg);
  endtask

  // Drive the receiver stall: a counted hold-off first, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    res_t want;
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ramp_value  = ramp_value_o;
      got.value_valid = value_valid_o;
      got.done_pulse  = done_pulse_o;
      got.is_running  = is_running_o;
      if (pending_ramp_q.size() == 0) begin
        note_failure($sformatf("unexpected transaction: value %0d valid %0b done %0b run %0b",
                               got.ramp_value, got.value_valid, got.done_pulse,
                               got.is_running));
      end else begin
        want = pending_ramp_q.pop_front();
        if (got.ramp_value !== want.ramp_value || got.value_valid !== want.value_valid ||
            got.done_pulse !== want.done_pulse || got.is_running !== want.is_running) begin
          note_failure($sformatf(
            "mismatch: expected value %0d valid %0b done %0b run %0b, got %0d %0b %0b %0b",
            want.ramp_value, want.value_valid, want.done_pulse, want.is_running,
            got.ramp_value, got.value_valid, got.done_pulse, got.is_running));
        end
      end
    end
  end

  // Offer one tick after a random gap and hold it until taken
  task automatic send_tick(input logic [DeltaW-1:0] delta, input logic restart);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i   <= 1'b0;
      tick_delta_i <= DeltaW'($urandom);
      restart_i    <= 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tick_delta_i <= delta;
    restart_i    <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_ramp_q.push_back(predict_tick(delta, restart));
  endtask

  // Drop valid and wait for every predicted transaction, then let the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_ramp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      RegDuration:   cfg_q.duration     = data[DurW-1:0];
      RegStartDelay: cfg_q.start_delay  = data[DurW-1:0];
      RegRepeat:     cfg_q.repeat_count = data[RepW-1:0];
      RegYoyo:       cfg_q.yoyo_enable  = data[0];
      RegStartValue: cfg_q.start_value  = data[ValW-1:0];
      RegEndValue:   cfg_q.end_value    = data[ValW-1:0];
      default: ;
    endcase
  endtask

  // Write all registers, with junk in any unused upper bits, plus one unused index
  task automatic set_config(input logic [DurW-1:0] dur, input logic [DurW-1:0] dly,
                            input logic signed [RepW-1:0] rep, input logic yoyo,
                            input logic signed [ValW-1:0] sv,
                            input logic signed [ValW-1:0] ev);
    logic [CfgDataW-1:0] junk;
    wait_idle();
    junk = $urandom();
    reg_write(RegDuration,   {junk[CfgDataW-1:DurW], dur});
    junk = $urandom();
    reg_write(RegStartDelay, {junk[CfgDataW-1:DurW], dly});
    junk = $urandom();
    reg_write(RegRepeat,     {junk[CfgDataW-1:RepW], rep});
    junk = $urandom();
    reg_write(RegYoyo,       {junk[CfgDataW-1:1], yoyo});
    reg_write(RegStartValue, sv);
    reg_write(RegEndValue,   ev);
    reg_write($urandom_range(1, 0) ? RegUnusedHi : RegUnusedLo, $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_p);
    send_idle_pct = send_pct;
    stall_pct     = stall_p;
  endtask

  // Delta mostly sized to the duration so that cycles complete within a phase
  function automatic logic [DeltaW-1:0] random_delta();
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(99, 0);
    if (pick < 15) return DeltaW'($urandom);
    if (pick < 22) return '0;
    if (pick < 27) return DeltaMax;
    step = cfg_q.duration / $urandom_range(40, 3) + $urandom_range(3, 0);
    return (step > DeltaMax) ? DeltaW'($urandom) : DeltaW'(step);
  endfunction

  task automatic test_idle_after_reset();
    send_tick(DeltaMax, 1'b0);
    send_tick('0, 1'b0);
  endtask

  task automatic test_default_ramp();
    send_tick(16'h8000, 1'b1);
    send_tick(DeltaMax, 1'b0);
  endtask

  // Full-scale ramp both ways, landing exactly on the duration once
  task automatic test_full_swing();
    set_config(24'd65536, '0, '0, 1'b0, ValMin, ValMax);
    send_tick(16'h4000, 1'b1);
    send_tick(DeltaMax, 1'b0);
    set_config(24'd65536, '0, '0, 1'b0, ValMax, ValMin);
    send_tick(DeltaMax, 1'b1);
    send_tick(16'd1, 1'b0);
    send_tick(16'd1, 1'b0);
  endtask

  task automatic test_rewind_repeat();
    set_config(24'd100000, 24'd20000, 9'sd2, 1'b0, -32'sd1000, 32'sd5000);
    send_tick(16'h2000, 1'b1);
    send_tick(DeltaMax, 1'b0);
    send_tick(DeltaMax, 1'b0);
  endtask

  // Overshoot past the duration flips and clamps; leave the tween counting down
  task automatic test_yoyo_overshoot();
    set_config(24'd70000, 24'd1000, -9'sd1, 1'b1, 32'sd123456, -32'sd654321);
    send_tick(DeltaMax, 1'b1);
    send_tick(DeltaMax, 1'b0);
    send_tick(DeltaMax, 1'b0);
    send_tick(16'h8000, 1'b0);
  endtask

  // Still counting down from the yoyo run, now rewinding at zero
  task automatic test_down_without_yoyo();
    set_config(24'd70000, 24'd1000, 9'sd1, 1'b0, 32'sd123456, -32'sd654321);
    send_tick(DeltaMax, 1'b0);
    send_tick('0, 1'b0);
    send_tick(16'd1, 1'b0);
  endtask

  task automatic test_delay_at_duration();
    set_config(24'd5000, 24'd5000, '0, 1'b0, 32'sd7, -32'sd9);
    send_tick(16'd5000, 1'b1);
  endtask

  task automatic test_zero_duration();
    set_config('0, '0, 9'sd1, 1'b0, -32'sd77, 32'sd88);
    send_tick('0, 1'b1);
    send_tick(16'd1, 1'b0);
    send_tick(16'd1, 1'b0);
  endtask

  // Hold the receiver off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    set_config(24'd200000, 24'd10000, -9'sd1, 1'b1, $urandom(), $urandom());
    set_idling(0, 0);
    hold_left = 400;
    send_tick(random_delta(), 1'b1);
    repeat (14) send_tick(random_delta(), 1'b0);
  endtask

  // Pause the sender until every transaction is back, then carry on
  task automatic test_sender_pause();
    set_config(24'd150000, 24'd30000, 9'sd3, 1'b0, $urandom(), $urandom());
    set_idling(22, 22);
    send_tick(random_delta(), 1'b1);
    repeat (7) send_tick(random_delta(), 1'b0);
    wait_idle();
    repeat (8) send_tick(random_delta(), 1'b0);
  endtask

  // Random configuration per phase, idling pattern cycling through the modes
  task automatic test_random_phases();
    logic [DurW-1:0]        dur;
    logic [DurW-1:0]        dly;
    logic signed [RepW-1:0] rep;
    logic signed [ValW-1:0] sv;
    logic signed [ValW-1:0] ev;
    int unsigned            pick;
    for (int p = 0; p < 10; p++) begin
      pick = $urandom_range(99, 0);
      if (pick < 50)      dur = $urandom_range(200000, 1000);
      else if (pick < 70) dur = $urandom_range(2000, 1);
      else if (pick < 80) dur = {DurW{1'b1}};
      else                dur = DurW'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 40)      dly = '0;
      else if (pick < 80) dly = DurW'($urandom_range(dur, 0));
      else if (pick < 90) dly = dur;
      else                dly = DurW'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 30)      rep = '0;
      else if (pick < 60) rep = RepW'($urandom_range(4, 1));
      else if (pick < 75) rep = -9'sd1;
      else if (pick < 85) rep = 9'sd255;
      else                rep = RepW'($urandom);
      pick = $urandom_range(99, 0);
      sv = (pick < 10) ? ValMin : $urandom();
      ev = (pick >= 90) ? ValMax : $urandom();
      set_config(dur, dly, rep, 1'($urandom), sv, ev);
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(82, 0);
        2: set_idling(0, 82);
        default: set_idling(22, 22);
      endcase
      send_tick(random_delta(), $urandom_range(9, 0) != 0);
      repeat (41) send_tick(random_delta(), $urandom_range(24, 0) == 0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    tick_delta_i  = '0;
    restart_i     = 1'b0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    fail_cnt      = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;

    // Predictor reset state
    cfg_q              = '0;
    cfg_q.duration     = DurationRst;
    elapsed_q          = 0;
    count_down_q       = 1'b0;
    repeats_left_q     = 0;
    running_q          = 1'b0;
    finished_q         = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_idle_after_reset();
    test_default_ramp();
    test_full_swing();
    test_rewind_repeat();
    test_yoyo_overshoot();
    test_down_without_yoyo();
    test_delay_at_duration();
    test_zero_duration();
    test_backpressure();
    test_sender_pause();
    test_random_phases();

    // Drain, then let the last transaction leave the block
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int unsigned n = 0; n < DrainLimit && pending_ramp_q.size() != 0; n++) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);
    if (pending_ramp_q.size() != 0) begin
      note_failure($sformatf("%0d transactions never arrived", pending_ramp_q.size()));
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### tween_ramp_interpolator_unit.f
rtl/core/twri_pkg.sv
rtl/core/twri_alu.sv
rtl/core/twri_core.sv
rtl/core/tween_ramp_interpolator_unit.sv
dv/tb_tween_ramp_interpolator_unit.sv
